### src/bft_pkg.sv
// Shared types, constants and command/status structs for the bigram frequency table.
package bft_pkg;

   localparam int ENTRIES_DEFAULT     = 128;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int SAMPLE_W    = 16;
   localparam int IDX_W       = 7;
   localparam int SLOT_W      = 7;
   localparam int RSP_COUNT_W = 16;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] sample;
      logic [IDX_W-1:0]           index;
   } req_type;

   typedef struct packed {
      logic                       window_ready;
      logic                       hit;
      logic [SLOT_W-1:0]          slot;
      logic [RSP_COUNT_W-1:0]     count;
      logic                       entry_valid;
      logic signed [SAMPLE_W-1:0] entry_first;
      logic signed [SAMPLE_W-1:0] entry_second;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_RD,
      ST_READ_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_MISS,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_ZERO,
      RES_READ_NONE,
      RES_READ_MEM,
      RES_HIT,
      RES_MISS
   } res_sel_type;

   typedef struct packed {
      logic        latch_req;
      logic        take_first;
      logic        start_scan;
      logic        start_read;
      logic        mem_read;
      logic        scan_next;
      logic        wr_hit;
      logic        wr_miss;
      res_sel_type res_sel;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic seen;
      logic read_valid;
      logic table_empty;
      logic match;
      logic scan_last;
      logic rsp_free;
   } status_type;

endpackage

### src/bigram_frequency_table.sv
// Bigram frequency table top level: controller and datapath around one table RAM.
// Sequencing: a read of an empty or out-of-range slot and the first sample go from decode
// straight to emit; a read of a stored slot adds a RAM read and a wait state; a push reads
// and compares stored entries one at a time, oldest first, over the one RAM read port.
// Throughput: one word at a time; the next word is taken the cycle after the result is registered.
// Reset: synchronous; the fill count empties the table at once, with no clearing pass.
module bigram_frequency_table import bft_pkg::*; #(
   parameter int ENTRIES     = ENTRIES_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   cmd_type    cmd;
   status_type status;

   bft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bft_dpath #(
      .ENTRIES     (ENTRIES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

### src/bft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bft_dpath.sv
// Datapath: request and result registers, ring-buffer table pointers and the table memory.
module bft_dpath import bft_pkg::*; #(
   parameter int ENTRIES     = ENTRIES_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_word,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp_word
);

   localparam int AW = $clog2(ENTRIES);
   localparam int NW = $clog2(ENTRIES + 1);
   localparam int XW = (NW > IDX_W) ? NW : IDX_W;
   localparam int DW = 2 * SAMPLE_W + COUNT_WIDTH;

   req_type                    req_ff, req_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                       seen_ff, seen_in;
   logic signed [SAMPLE_W-1:0] key_first_ff, key_first_in;
   logic [AW-1:0]              head_ff, head_in;
   logic [NW-1:0]              fill_ff, fill_in;
   logic [AW-1:0]              scan_idx_ff, scan_idx_in;
   logic [AW-1:0]              scan_ptr_ff, scan_ptr_in;
   rsp_type                    res_ff, res_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [DW-1:0]              wr_data;
   logic [DW-1:0]              rd_data;
   logic signed [SAMPLE_W-1:0] rd_first;
   logic signed [SAMPLE_W-1:0] rd_second;
   logic [COUNT_WIDTH-1:0]     rd_count;
   logic [COUNT_WIDTH-1:0]     cnt_inc;
   logic [XW-1:0]              idx_x;
   logic [NW-1:0]              oldest_valid;
   logic [AW-1:0]              start_ix;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (AW + 1)'(ENTRIES)) begin
         s = s - (AW + 1)'(ENTRIES);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
      logic [AW-1:0] r;
      if (a == AW'(ENTRIES - 1)) begin
         r = '0;
      end else begin
         r = a + AW'(1);
      end
      return r;
   endfunction

   assign rd_first  = rd_data[DW-1 -: SAMPLE_W];
   assign rd_second = rd_data[COUNT_WIDTH +: SAMPLE_W];
   assign rd_count  = rd_data[COUNT_WIDTH-1:0];
   assign cnt_inc   = (rd_count == '1) ? rd_count : rd_count + COUNT_WIDTH'(1);

   assign idx_x        = XW'(req_ff.index);
   assign oldest_valid = NW'(ENTRIES) - fill_ff;
   assign start_ix     = AW'(oldest_valid);

   assign status.is_read     = (req_ff.op == OP_READ);
   assign status.seen        = seen_ff;
   assign status.read_valid  = (idx_x < XW'(ENTRIES)) && (idx_x >= XW'(oldest_valid));
   assign status.table_empty = (fill_ff == '0);
   assign status.match       = (rd_first == key_first_ff) && (rd_second == req_ff.sample);
   assign status.scan_last   = (scan_idx_ff == AW'(ENTRIES - 1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign wr_en   = cmd.wr_hit || cmd.wr_miss;
   assign wr_addr = cmd.wr_hit ? scan_ptr_ff : head_ff;
   assign wr_data = cmd.wr_hit ? {rd_first, rd_second, cnt_inc}
                               : {key_first_ff, req_ff.sample, COUNT_WIDTH'(1)};

   bft_ram #(
      .WIDTH (DW),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (scan_ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      req_in       = req_ff;
      prev_in      = prev_ff;
      seen_in      = seen_ff;
      key_first_in = key_first_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      scan_idx_in  = scan_idx_ff;
      scan_ptr_in  = scan_ptr_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.latch_req) begin
         req_in = req_word;
      end
      if (cmd.take_first) begin
         prev_in = req_ff.sample;
         seen_in = 1'b1;
      end
      if (cmd.start_scan) begin
         key_first_in = prev_ff;
         prev_in      = req_ff.sample;
         scan_idx_in  = start_ix;
         scan_ptr_in  = wrap_add(head_ff, start_ix);
      end
      if (cmd.start_read) begin
         scan_idx_in = idx_x[AW-1:0];
         scan_ptr_in = wrap_add(head_ff, idx_x[AW-1:0]);
      end
      if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + AW'(1);
         scan_ptr_in = wrap_inc(scan_ptr_ff);
      end
      if (cmd.wr_miss) begin
         head_in = wrap_inc(head_ff);
         if (fill_ff != NW'(ENTRIES)) begin
            fill_in = fill_ff + NW'(1);
         end
      end

      case (cmd.res_sel)
         RES_HOLD: begin
            res_in = res_ff;
         end
         RES_ZERO: begin
            res_in = '0;
         end
         RES_READ_NONE: begin
            res_in      = '0;
            res_in.slot = req_ff.index;
         end
         RES_READ_MEM: begin
            res_in.window_ready = 1'b0;
            res_in.hit          = 1'b0;
            res_in.slot         = req_ff.index;
            res_in.count        = RSP_COUNT_W'(rd_count);
            res_in.entry_valid  = 1'b1;
            res_in.entry_first  = rd_first;
            res_in.entry_second = rd_second;
         end
         RES_HIT: begin
            res_in.window_ready = 1'b1;
            res_in.hit          = 1'b1;
            res_in.slot         = SLOT_W'(scan_idx_ff);
            res_in.count        = RSP_COUNT_W'(cnt_inc);
            res_in.entry_valid  = 1'b1;
            res_in.entry_first  = rd_first;
            res_in.entry_second = rd_second;
         end
         RES_MISS: begin
            res_in.window_ready = 1'b1;
            res_in.hit          = 1'b0;
            res_in.slot         = SLOT_W'(ENTRIES - 1);
            res_in.count        = RSP_COUNT_W'(1);
            res_in.entry_valid  = 1'b1;
            res_in.entry_first  = key_first_ff;
            res_in.entry_second = req_ff.sample;
         end
         default: begin
            res_in = res_ff;
         end
      endcase

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      prev_ff      <= prev_in;
      key_first_ff <= key_first_in;
      scan_idx_ff  <= scan_idx_in;
      scan_ptr_ff  <= scan_ptr_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         seen_ff      <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### src/bft_ctrl.sv
// Controller state machine that sequences decode, slot read, table scan, update and result hand-off.
module bft_ctrl import bft_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_read) begin
               if (status.read_valid) begin
                  cmd.start_read = 1'b1;
                  state_in       = ST_READ_RD;
               end else begin
                  cmd.res_sel = RES_READ_NONE;
                  state_in    = ST_EMIT;
               end
            end else if (!status.seen) begin
               cmd.take_first = 1'b1;
               cmd.res_sel    = RES_ZERO;
               state_in       = ST_EMIT;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = status.table_empty ? ST_MISS : ST_SCAN_RD;
            end
         end
         ST_READ_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            cmd.res_sel = RES_READ_MEM;
            state_in    = ST_EMIT;
         end
         ST_SCAN_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (status.match) begin
               cmd.wr_hit  = 1'b1;
               cmd.res_sel = RES_HIT;
               state_in    = ST_EMIT;
            end else if (status.scan_last) begin
               state_in = ST_MISS;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_MISS: begin
            cmd.wr_miss = 1'b1;
            cmd.res_sel = RES_MISS;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### test/tb_bigram_frequency_table.sv
`timescale 1ns / 1ps
// Testbench for the bigram frequency table: directed and random words checked against a pair-table predictor.
module tb_bigram_frequency_table;
   import bft_pkg::*;

   localparam int SLOTS = ENTRIES_DEFAULT;
   localparam logic [COUNT_WIDTH_DEFAULT-1:0] COUNT_MAX = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   logic signed [SAMPLE_W-1:0]    pair_first  [SLOTS];
   logic signed [SAMPLE_W-1:0]    pair_second [SLOTS];
   logic [COUNT_WIDTH_DEFAULT-1:0] pair_count  [SLOTS];
   logic                          pair_valid  [SLOTS];
   logic signed [SAMPLE_W-1:0]    last_sample;
   logic                          sample_held;

   rsp_type expected_rsps [$];
   logic    send_idle;
   logic    recv_idle;
   int      errors;
   int      n_reads;
   int      n_hits;
   int      n_inserts;
   int      n_saturated;

   logic signed [SAMPLE_W-1:0] symbols [16];
   int                         n_symbols;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bigram_frequency_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   function automatic rsp_type slot_view(input int s);
      rsp_type r;
      r = '0;
      r.slot = SLOT_W'(s);
      if (s < SLOTS) begin
         r.count        = RSP_COUNT_W'(pair_count[s]);
         r.entry_valid  = pair_valid[s];
         r.entry_first  = pair_first[s];
         r.entry_second = pair_second[s];
      end
      return r;
   endfunction

   function automatic rsp_type update_pair_table(input req_type w);
      rsp_type r;
      int      found;
      int      i;
      r = '0;
      found = -1;
      if (w.op == OP_READ) begin
         n_reads++;
         return slot_view(int'(w.index));
      end
      if (!sample_held) begin
         last_sample = w.sample;
         sample_held = 1'b1;
         return r;
      end
      for (i = 0; i < SLOTS; i++) begin
         if (found < 0 && pair_valid[i] && pair_first[i] == last_sample
             && pair_second[i] == w.sample) begin
            found = i;
         end
      end
      if (found >= 0) begin
         if (pair_count[found] != COUNT_MAX) begin
            pair_count[found]++;
         end else begin
            n_saturated++;
         end
         n_hits++;
         r = slot_view(found);
         r.hit = 1'b1;
      end else begin
         for (i = 0; i < SLOTS - 1; i++) begin
            pair_first[i]  = pair_first[i+1];
            pair_second[i] = pair_second[i+1];
            pair_count[i]  = pair_count[i+1];
            pair_valid[i]  = pair_valid[i+1];
         end
         pair_first[SLOTS-1]  = last_sample;
         pair_second[SLOTS-1] = w.sample;
         pair_count[SLOTS-1]  = COUNT_WIDTH_DEFAULT'(1);
         pair_valid[SLOTS-1]  = 1'b1;
         n_inserts++;
         r = slot_view(SLOTS - 1);
      end
      r.window_ready = 1'b1;
      last_sample = w.sample;
      return r;
   endfunction

   function automatic req_type push_word(input logic signed [SAMPLE_W-1:0] s);
      req_type w;
      w.op     = OP_PUSH;
      w.sample = s;
      w.index  = IDX_W'($urandom);
      return w;
   endfunction

   function automatic req_type read_word(input logic [IDX_W-1:0] idx);
      req_type w;
      w.op     = OP_READ;
      w.sample = SAMPLE_W'($urandom);
      w.index  = idx;
      return w;
   endfunction

   task automatic send_word(input req_type w);
      int gap;
      gap = send_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_rsps.push_back(update_pair_table(w));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         $error("result word %h arrived with nothing pending", got);
         errors++;
         return;
      end
      want = expected_rsps.pop_front();
      if (got.window_ready !== want.window_ready) begin
         $error("window_ready: expected %0d, got %0d", want.window_ready, got.window_ready);
         errors++;
      end
      if (got.hit !== want.hit) begin
         $error("hit: expected %0d, got %0d", want.hit, got.hit);
         errors++;
      end
      if (got.slot !== want.slot) begin
         $error("slot: expected %0d, got %0d", want.slot, got.slot);
         errors++;
      end
      if (got.count !== want.count) begin
         $error("count: expected %0d, got %0d", want.count, got.count);
         errors++;
      end
      if (got.entry_valid !== want.entry_valid) begin
         $error("entry_valid: expected %0d, got %0d", want.entry_valid, got.entry_valid);
         errors++;
      end
      if (got.entry_first !== want.entry_first) begin
         $error("entry_first: expected %0d, got %0d", want.entry_first, got.entry_first);
         errors++;
      end
      if (got.entry_second !== want.entry_second) begin
         $error("entry_second: expected %0d, got %0d", want.entry_second, got.entry_second);
         errors++;
      end
   endtask

   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = recv_idle ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_result(rsp_word);
      end
   end

   task automatic test_startup();
      send_word(read_word(IDX_W'(0)));
      send_word(read_word(IDX_W'(SLOTS - 1)));
      send_word(read_word(IDX_W'(1)));
      send_word(push_word(16'sh7FFF));
   endtask

   task automatic test_pair_lookup();
      send_word(push_word(16'sh8000));
      send_word(push_word(16'sh0000));
      send_word(push_word(16'shFFFF));
      send_word(push_word(16'sh7FFF));
      send_word(push_word(16'sh8000));
      send_word(push_word(16'sh0000));
      send_word(push_word(16'sh0000));
      send_word(push_word(16'sh0000));
      send_word(push_word(16'sh5555));
      send_word(push_word(16'shAAAA));
      send_word(read_word(IDX_W'(SLOTS - 1)));
      send_word(read_word(IDX_W'(SLOTS - 2)));
      send_word(read_word(IDX_W'(SLOTS - 5)));
      send_word(read_word(IDX_W'(SLOTS - 8)));
      send_word(read_word(IDX_W'(0)));
   endtask

   task automatic test_repeated_pair();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      send_word(push_word(16'sh0003));
      repeat (40) send_word(push_word(16'sh0003));
      send_word(read_word(IDX_W'(SLOTS - 1)));
   endtask

   task automatic test_random_stream();
      int seg;
      int k;
      int read_pct;
      for (seg = 0; seg < 14; seg++) begin
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         n_symbols = 2 << $urandom_range(0, 3);
         for (k = 0; k < n_symbols; k++) symbols[k] = SAMPLE_W'($urandom);
         symbols[0] = (seg % 2 == 1) ? 16'sh7FFF : 16'sh8000;
         read_pct = $urandom_range(5, 40);
         for (k = 0; k < 100; k++) begin
            if ($urandom_range(0, 99) < read_pct) begin
               send_word(read_word(IDX_W'($urandom)));
            end else if ($urandom_range(0, 99) < 80) begin
               send_word(push_word(symbols[$urandom_range(0, n_symbols - 1)]));
            end else begin
               send_word(push_word(SAMPLE_W'($urandom)));
            end
         end
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < SLOTS; i++) begin
         pair_first[i]  = '0;
         pair_second[i] = '0;
         pair_count[i]  = '0;
         pair_valid[i]  = 1'b0;
      end
      last_sample = '0;
      sample_held = 1'b0;
      errors      = 0;
      n_reads     = 0;
      n_hits      = 0;
      n_inserts   = 0;
      n_saturated = 0;
      send_idle   = 1'b1;
      recv_idle   = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_startup();
      test_pair_lookup();
      test_repeated_pair();
      test_random_stream();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Run covered %0d slot reads, %0d pair hits and %0d pair inserts.",
               n_reads, n_hits, n_inserts);
      $display("Hits on a count already at its ceiling: %0d.", n_saturated);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### bigram_frequency_table.f
src/bft_pkg.sv
src/bft_ram.sv
src/bft_dpath.sv
src/bft_ctrl.sv
src/bigram_frequency_table.sv
test/tb_bigram_frequency_table.sv
